// ===== hdl/sgs_pkg.sv =====
// Package for the swipe gesture sequencer: phase type, codes and arithmetic constants.
`default_nettype none

package sgs_pkg;

   // Gesture phases
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEAD = 3'd1,
      PH_DRAG = 3'd2,
      PH_REL  = 3'd3,
      PH_RET  = 3'd4
   } phase_type;

   // Request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_ABORT = 2'd2;

   // Start directions
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   // Register indexes
   localparam logic CSR_DISTANCE = 1'b0;
   localparam logic CSR_SPEED    = 1'b1;

   // Field widths
   localparam int DIST_REG_W  = 12;
   localparam int SPEED_REG_W = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int STEP_W      = 7;
   localparam int MOVE_W      = 8;

   // Defaults and limits
   localparam int DISTANCE_MAX_DEFAULT = 4095;
   localparam int DISTANCE_REG_MAX     = 4095;
   localparam int DISTANCE_RESET       = 300;
   localparam int STEP_RESET           = 22;
   localparam int STEP_LIMIT           = 127;
   localparam int LEAD_PX              = 14;
   localparam int H_NUM                = 6;
   localparam int H_DEN                = 13;

   // Horizontal scale d*6/13 as d*(6*ceil(2^20/13)) >> 20, exact for d below 2^12
   localparam int HD_SHIFT = 20;
   localparam int HD_MUL_W = 19;
   localparam logic [HD_MUL_W-1:0] HD_MUL = 19'd483960;
   localparam int HD_PROD_W = DIST_REG_W + HD_MUL_W;

   // Step size ceil(s*22/1000) as (s*22*M + 999*M) >> 27, M = ceil(2^27/1000)
   localparam int CH_SHIFT  = 27;
   localparam int CH_MUL_W  = 22;
   localparam int CH_PROD_W = 35;
   localparam logic [CH_MUL_W-1:0]  CH_MUL = 22'd2952796;
   localparam logic [CH_PROD_W-1:0] CH_ADD = 35'd134083782;
   // Lowest speed whose step size goes past the limit
   localparam logic [SPEED_REG_W-1:0] SPEED_SAT = 16'd5773;

endpackage

`default_nettype wire

// ===== hdl/swipe_gesture_sequencer.sv =====
// Swipe gesture sequencer: turns tick, start and abort words into relative-move reports.
`default_nettype none

// Each request word gives exactly one response word, in order. Requests pass an input
// register and then a result register, and one word per cycle is sustained while
// rsp_ready stays high; the state update between the two registers is a few compares
// and adds. A stalled response holds only the result register while the next request
// waits in the input register. Configuration writes are registered and csr_ready is
// always high; the step size and the horizontal travel are worked out at write time
// with one constant multiplier each. Write configuration only with no request in flight.
module swipe_gesture_sequencer #(
   parameter int DISTANCE_MAX = sgs_pkg::DISTANCE_MAX_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_action,
   input  wire logic [1:0]                     req_direction,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [sgs_pkg::MOVE_W-1:0]   rsp_move_x,
   output logic signed [sgs_pkg::MOVE_W-1:0]   rsp_move_y,
   output logic                                rsp_press_button,
   output logic                                rsp_release_button,
   output logic                                rsp_start_rejected,
   output logic                                rsp_running,
   // configuration channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [sgs_pkg::CSR_DATA_W-1:0] csr_data
);
   import sgs_pkg::*;

   // Effective distance limit and travel widths
   localparam int DIST_LIM = (DISTANCE_MAX < DISTANCE_REG_MAX) ? DISTANCE_MAX
                                                               : DISTANCE_REG_MAX;
   localparam int DW = $clog2(DIST_LIM + 1);
   localparam int TW = DW + 1;
   localparam int DIST_RST = (DISTANCE_RESET < DIST_LIM) ? DISTANCE_RESET : DIST_LIM;
   localparam int HD_RST   = DIST_RST * H_NUM / H_DEN;

   // Pipeline control
   logic                    in_valid_ff, in_valid_in;
   logic [1:0]              in_action_ff, in_action_in;
   logic [1:0]              in_dir_ff, in_dir_in;
   logic                    req_accept;
   logic                    advance;

   // Configuration derived values
   logic [DW-1:0]           dist_ff, dist_in;
   logic [DW-1:0]           hd_ff, hd_in;
   logic [STEP_W-1:0]       chunk_ff, chunk_in;
   logic [DIST_REG_W-1:0]   csr_dist;
   logic [HD_PROD_W-1:0]    hd_prod;
   logic [SPEED_REG_W-1:0]  csr_speed;
   logic [CH_PROD_W-1:0]    ch_prod;
   logic [STEP_W-1:0]       ch_quot;

   // Gesture state
   phase_type               phase_ff, phase_in;
   logic signed [TW-1:0]    left_x_ff, left_x_in;
   logic signed [TW-1:0]    left_y_ff, left_y_in;
   logic signed [TW-1:0]    whole_x_ff, whole_x_in;
   logic signed [TW-1:0]    whole_y_ff, whole_y_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   // Step outputs
   logic signed [TW-1:0]    mv_x, mv_y;
   logic                    press, release_b, rejected;
   logic signed [TW-1:0]    start_x, start_y;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MOVE_W-1:0]       rsp_x_ff, rsp_x_in;
   logic [MOVE_W-1:0]       rsp_y_ff, rsp_y_in;
   logic                    rsp_press_ff, rsp_press_in;
   logic                    rsp_rel_ff, rsp_rel_in;
   logic                    rsp_rej_ff, rsp_rej_in;
   logic                    rsp_run_ff, rsp_run_in;

   // Lead move: up to LEAD_PX, leaving at least one pixel where possible
   function automatic logic signed [TW-1:0] lead_amt(input logic signed [TW-1:0] rem);
      logic [TW-1:0] mag;
      logic [TW-1:0] cap;
      logic [TW-1:0] amt;
      mag = rem[TW-1] ? $unsigned(-rem) : $unsigned(rem);
      cap = (mag > TW'(2)) ? mag - TW'(1) : TW'(1);
      amt = (cap > TW'(LEAD_PX)) ? TW'(LEAD_PX) : cap;
      return rem[TW-1] ? -$signed(amt) : $signed(amt);
   endfunction

   // Drag chunk: remaining travel clamped to plus or minus the step size
   function automatic logic signed [TW-1:0] clamp_step(input logic signed [TW-1:0] rem,
                                                       input logic [STEP_W-1:0] chunk);
      logic signed [TW-1:0] c;
      c = $signed({{(TW-STEP_W){1'b0}}, chunk});
      if (rem > c) begin
         return c;
      end else if (rem < -c) begin
         return -c;
      end
      return rem;
   endfunction

   // Handshakes
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // Capture the request word
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_action_in = in_action_ff;
      in_dir_in    = in_dir_ff;
      if (req_accept) begin
         in_valid_in  = 1'b1;
         in_action_in = req_action;
         in_dir_in    = req_direction;
      end else if (advance) begin
         in_valid_in  = 1'b0;
      end
   end

   // Saturate distance and scale it for horizontal travel
   assign csr_dist = csr_data[DIST_REG_W-1:0];
   always_comb begin
      dist_in = dist_ff;
      if (csr_dist > DIST_REG_W'(DIST_LIM)) begin
         dist_in = DW'(DIST_LIM);
      end else begin
         dist_in = DW'(csr_dist);
      end
   end
   assign hd_prod = HD_PROD_W'(dist_in) * HD_PROD_W'(HD_MUL);
   assign hd_in   = DW'(hd_prod >> HD_SHIFT);

   // Turn the speed into a per-tick step size
   assign csr_speed = csr_data[SPEED_REG_W-1:0];
   assign ch_prod   = CH_PROD_W'(csr_speed) * CH_PROD_W'(CH_MUL) + CH_ADD;
   assign ch_quot   = ch_prod[CH_SHIFT +: STEP_W];
   always_comb begin
      if (csr_speed >= SPEED_SAT) begin
         chunk_in = STEP_W'(STEP_LIMIT);
      end else if (ch_quot == '0) begin
         chunk_in = STEP_W'(1);
      end else begin
         chunk_in = ch_quot;
      end
   end

   // Travel opposite to the start direction
   always_comb begin
      start_x = '0;
      start_y = '0;
      unique case (in_dir_ff)
         DIR_RIGHT: start_x = -$signed({1'b0, hd_ff});
         DIR_LEFT:  start_x = $signed({1'b0, hd_ff});
         DIR_DOWN:  start_y = -$signed({1'b0, dist_ff});
         DIR_UP:    start_y = $signed({1'b0, dist_ff});
      endcase
   end

   // Outputs of the current step
   always_comb begin
      mv_x      = '0;
      mv_y      = '0;
      press     = 1'b0;
      release_b = 1'b0;
      rejected  = 1'b0;
      case (in_action_ff)
         ACT_START: begin
            rejected = (phase_ff != PH_IDLE);
         end
         ACT_ABORT: begin
            release_b = (phase_ff == PH_DRAG) || (phase_ff == PH_REL);
         end
         ACT_TICK: begin
            case (phase_ff)
               PH_LEAD: begin
                  press = 1'b1;
                  if (left_x_ff != '0) begin
                     mv_x = lead_amt(left_x_ff);
                  end else if (left_y_ff != '0) begin
                     mv_y = lead_amt(left_y_ff);
                  end
               end
               PH_DRAG, PH_RET: begin
                  if (left_x_ff != '0) begin
                     mv_x = clamp_step(left_x_ff, step_ff);
                  end else if (left_y_ff != '0) begin
                     mv_y = clamp_step(left_y_ff, step_ff);
                  end
               end
               PH_REL: begin
                  release_b = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Next gesture state
   always_comb begin
      phase_in   = phase_ff;
      left_x_in  = left_x_ff;
      left_y_in  = left_y_ff;
      whole_x_in = whole_x_ff;
      whole_y_in = whole_y_ff;
      step_in    = step_ff;
      if (advance) begin
         case (in_action_ff)
            ACT_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in   = PH_LEAD;
                  left_x_in  = start_x;
                  left_y_in  = start_y;
                  whole_x_in = start_x;
                  whole_y_in = start_y;
                  step_in    = chunk_ff;
               end
            end
            ACT_ABORT: begin
               phase_in   = PH_IDLE;
               left_x_in  = '0;
               left_y_in  = '0;
               whole_x_in = '0;
               whole_y_in = '0;
            end
            ACT_TICK: begin
               case (phase_ff)
                  PH_LEAD: begin
                     left_x_in = left_x_ff - mv_x;
                     left_y_in = left_y_ff - mv_y;
                     phase_in  = PH_DRAG;
                  end
                  PH_DRAG, PH_RET: begin
                     left_x_in = left_x_ff - mv_x;
                     left_y_in = left_y_ff - mv_y;
                     if ((left_x_ff == '0) && (left_y_ff == '0)) begin
                        if (phase_ff == PH_DRAG) begin
                           phase_in = PH_REL;
                        end else begin
                           phase_in   = PH_IDLE;
                           whole_x_in = '0;
                           whole_y_in = '0;
                        end
                     end
                  end
                  PH_REL: begin
                     phase_in  = PH_RET;
                     left_x_in = -whole_x_ff;
                     left_y_in = -whole_y_ff;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Load or drain the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_press_in = rsp_press_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_run_in   = rsp_run_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = mv_x[MOVE_W-1:0];
         rsp_y_in     = mv_y[MOVE_W-1:0];
         rsp_press_in = press;
         rsp_rel_in   = release_b;
         rsp_rej_in   = rejected;
         rsp_run_in   = (phase_in != PH_IDLE);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         left_x_ff    <= '0;
         left_y_ff    <= '0;
         whole_x_ff   <= '0;
         whole_y_ff   <= '0;
         step_ff      <= STEP_W'(1);
         dist_ff      <= DW'(DIST_RST);
         hd_ff        <= DW'(HD_RST);
         chunk_ff     <= STEP_W'(STEP_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         left_x_ff    <= left_x_in;
         left_y_ff    <= left_y_in;
         whole_x_ff   <= whole_x_in;
         whole_y_ff   <= whole_y_in;
         step_ff      <= step_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DISTANCE: begin
                  dist_ff <= dist_in;
                  hd_ff   <= hd_in;
               end
               CSR_SPEED: begin
                  chunk_ff <= chunk_in;
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_action_ff <= in_action_in;
      in_dir_ff    <= in_dir_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_press_ff <= rsp_press_in;
      rsp_rel_ff   <= rsp_rel_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_move_x         = $signed(rsp_x_ff);
   assign rsp_move_y         = $signed(rsp_y_ff);
   assign rsp_press_button   = rsp_press_ff;
   assign rsp_release_button = rsp_rel_ff;
   assign rsp_start_rejected = rsp_rej_ff;
   assign rsp_running        = rsp_run_ff;

   // Idle always means a cleared gesture
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> ((left_x_ff == '0) && (left_y_ff == '0) &&
                                 (whole_x_ff == '0) && (whole_y_ff == '0)))
      else $error("idle phase with travel left");

   // Drag never overshoots the travel
   a_drag_sign: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_DRAG) && (left_x_ff != '0)) |-> (left_x_ff[TW-1] == whole_x_ff[TW-1]))
      else $error("drag overshot horizontal travel");

   // A rejected start leaves a running swipe and moves nothing
   a_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_rejected) |-> (rsp_running && (rsp_move_x == '0) &&
                                             (rsp_move_y == '0) && !rsp_press_button))
      else $error("rejected start word with activity");

   // A press word always leads into the drag phase
   a_press_drag: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_action_ff == ACT_TICK) && (phase_ff == PH_LEAD)) |=>
         (phase_ff == PH_DRAG) && rsp_valid && rsp_press_button)
      else $error("lead step did not enter drag");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the swipe gesture sequencer: directed table, random gestures, scoreboard.
module tb_top;
   import sgs_pkg::*;

   // Action code that the block ignores
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int DISTANCE_LIMIT = DISTANCE_MAX_DEFAULT;
   localparam int TICK_MS = 22;
   localparam int ROUND_UP = 999;
   localparam int MS_PER_S = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_SETTING = 250;

   typedef struct packed {
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
      logic press_button;
      logic release_button;
      logic start_rejected;
      logic running;
   } move_report_type;

   typedef struct {
      bit is_csr;
      logic [1:0] action;
      logic [1:0] dir;
      logic idx;
      logic [CSR_DATA_W-1:0] val;
      bit typed;
      move_report_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_action, req_direction;
   logic rsp_valid, rsp_ready;
   logic signed [MOVE_W-1:0] rsp_move_x, rsp_move_y;
   logic rsp_press_button, rsp_release_button, rsp_start_rejected, rsp_running;
   logic csr_valid, csr_ready;
   logic csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   swipe_gesture_sequencer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_direction(req_direction),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_move_x(rsp_move_x),
      .rsp_move_y(rsp_move_y),
      .rsp_press_button(rsp_press_button),
      .rsp_release_button(rsp_release_button),
      .rsp_start_rejected(rsp_start_rejected),
      .rsp_running(rsp_running),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Gesture predictor state and its copy of the registers
   phase_type g_phase = PH_IDLE;
   int g_left_x = 0, g_left_y = 0, g_whole_x = 0, g_whole_y = 0, g_step = 1;
   int cfg_distance = DISTANCE_RESET;
   int cfg_speed = 1000;

   move_report_type pending_moves[$];
   int errors = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   int hold_asks = 0;

   // Lead move: up to LEAD_PX, leaving at least one pixel where possible
   function automatic int lead_px(int rem);
      int mag, cap, lead;
      mag = rem < 0 ? -rem : rem;
      cap = mag - 1;
      if (cap < 1) cap = 1;
      lead = LEAD_PX > cap ? cap : LEAD_PX;
      return rem < 0 ? -lead : lead;
   endfunction

   function automatic int chunk_px(int rem);
      if (rem > g_step) return g_step;
      if (rem < -g_step) return -g_step;
      return rem;
   endfunction

   function automatic void clear_gesture();
      g_phase = PH_IDLE;
      g_left_x = 0;
      g_left_y = 0;
      g_whole_x = 0;
      g_whole_y = 0;
   endfunction

   // Advance the gesture by one word and return the report it produces
   function automatic move_report_type advance_gesture(logic [1:0] act, logic [1:0] dir);
      move_report_type r;
      int dist_px, hd, chunk, mx, my;
      r = '0;
      mx = 0;
      my = 0;
      case (act)
         ACT_START: begin
            if (g_phase != PH_IDLE) begin
               r.start_rejected = 1'b1;
            end else begin
               dist_px = cfg_distance > DISTANCE_LIMIT ? DISTANCE_LIMIT : cfg_distance;
               hd = dist_px * H_NUM / H_DEN;
               chunk = (cfg_speed * TICK_MS + ROUND_UP) / MS_PER_S;
               if (chunk < 1) chunk = 1;
               if (chunk > STEP_LIMIT) chunk = STEP_LIMIT;
               g_left_x = 0;
               g_left_y = 0;
               // travel runs against the direction key
               case (dir)
                  DIR_RIGHT: g_left_x = -hd;
                  DIR_LEFT:  g_left_x = hd;
                  DIR_DOWN:  g_left_y = -dist_px;
                  default:   g_left_y = dist_px;
               endcase
               g_whole_x = g_left_x;
               g_whole_y = g_left_y;
               g_step = chunk;
               g_phase = PH_LEAD;
            end
         end
         ACT_ABORT: begin
            r.release_button = (g_phase == PH_DRAG || g_phase == PH_REL);
            clear_gesture();
         end
         ACT_TICK: begin
            case (g_phase)
               PH_LEAD: begin
                  if (g_left_x != 0) begin
                     mx = lead_px(g_left_x);
                     g_left_x -= mx;
                  end else if (g_left_y != 0) begin
                     my = lead_px(g_left_y);
                     g_left_y -= my;
                  end
                  r.press_button = 1'b1;
                  g_phase = PH_DRAG;
               end
               PH_DRAG, PH_RET: begin
                  if (g_left_x != 0) begin
                     mx = chunk_px(g_left_x);
                     g_left_x -= mx;
                  end else if (g_left_y != 0) begin
                     my = chunk_px(g_left_y);
                     g_left_y -= my;
                  end else if (g_phase == PH_DRAG) begin
                     g_phase = PH_REL;
                  end else begin
                     clear_gesture();
                  end
               end
               PH_REL: begin
                  r.release_button = 1'b1;
                  g_phase = PH_RET;
                  g_left_x = -g_whole_x;
                  g_left_y = -g_whole_y;
               end
               default: g_phase = PH_IDLE;
            endcase
         end
         default: ;
      endcase
      r.move_x = mx[MOVE_W-1:0];
      r.move_y = my[MOVE_W-1:0];
      r.running = (g_phase != PH_IDLE);
      return r;
   endfunction

   function automatic move_report_type mk_word(int mx, int my, bit p, bit rl, bit rj, bit run);
      move_report_type w;
      w.move_x = mx[MOVE_W-1:0];
      w.move_y = my[MOVE_W-1:0];
      w.press_button = p;
      w.release_button = rl;
      w.start_rejected = rj;
      w.running = run;
      return w;
   endfunction

   function automatic stim_row_type row_item(logic [1:0] act, logic [1:0] dir);
      stim_row_type s;
      s = '{default: '0};
      s.action = act;
      s.dir = dir;
      return s;
   endfunction

   function automatic stim_row_type row_typed(logic [1:0] act, logic [1:0] dir,
                                              move_report_type w);
      stim_row_type s;
      s = row_item(act, dir);
      s.typed = 1'b1;
      s.want = w;
      return s;
   endfunction

   function automatic stim_row_type row_csr(logic idx, logic [CSR_DATA_W-1:0] val);
      stim_row_type s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.idx = idx;
      s.val = val;
      return s;
   endfunction

   // Offer one request word, hold it until accepted, then record its report
   task automatic send_word(logic [1:0] act, logic [1:0] dir, bit typed, move_report_type w);
      move_report_type r;
      while (gaps_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_direction <= dir;
      do @(posedge clock); while (!req_ready);
      r = advance_gesture(act, dir);
      pending_moves.push_back(typed ? w : r);
      @(negedge clock);
   endtask

   // Drop the request and wait until every report has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_moves.size() != 0);
   endtask

   task automatic write_reg(logic idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DISTANCE) cfg_distance = int'(val[DIST_REG_W-1:0]);
      else cfg_speed = int'(val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_registers(int travel, int speed);
      drain();
      write_reg(CSR_DISTANCE, {4'($urandom_range(15)), 12'(travel)});
      write_reg(CSR_SPEED, 16'(speed));
   endtask

   // Mostly whole gestures with random directions, plus aborts, stray starts and noise
   task automatic run_gestures(int items);
      int sent, pick;
      bit paused;
      logic [1:0] act;
      sent = 0;
      paused = 1'b0;
      while (sent < items) begin
         if (!paused && sent >= items / 2) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (g_phase == PH_IDLE)
            act = pick < 80 ? ACT_START : pick < 88 ? ACT_TICK : pick < 94 ? ACT_ABORT : ACT_NONE;
         else
            act = pick < 88 ? ACT_TICK : pick < 93 ? ACT_START : pick < 96 ? ACT_ABORT : ACT_NONE;
         send_word(act, 2'($urandom_range(3)), 1'b0, '0);
         if (act != ACT_NONE) sent++;
      end
   endtask

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // Compare each accepted report with the oldest expectation
   always @(posedge clock) begin
      move_report_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_moves.size() == 0) begin
            $display("%0t: report with no request outstanding", $time);
            errors++;
         end else begin
            w = pending_moves.pop_front();
            check_field("move_x", int'($signed(w.move_x)), int'(rsp_move_x));
            check_field("move_y", int'($signed(w.move_y)), int'(rsp_move_y));
            check_field("press_button", w.press_button, rsp_press_button);
            check_field("release_button", w.release_button, rsp_release_button);
            check_field("start_rejected", w.start_rejected, rsp_start_rejected);
            check_field("running", w.running, rsp_running);
         end
      end
   end

   // Response side: random stalls, plus a long hold-off when asked
   initial begin
      int hold_left, hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(99) < 10);
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_TICK;
      req_direction = DIR_RIGHT;
      csr_valid = 1'b0;
      csr_index = CSR_DISTANCE;
      csr_data = '0;

      // Idle cases, start, rejected start and abort before the button goes down
      rows.push_back(row_typed(ACT_TICK, DIR_UP, mk_word(0, 0, 0, 0, 0, 0)));
      rows.push_back(row_typed(ACT_ABORT, DIR_LEFT, mk_word(0, 0, 0, 0, 0, 0)));
      rows.push_back(row_typed(ACT_NONE, DIR_UP, mk_word(0, 0, 0, 0, 0, 0)));
      rows.push_back(row_typed(ACT_START, DIR_UP, mk_word(0, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_START, DIR_RIGHT, mk_word(0, 0, 0, 0, 1, 1)));
      rows.push_back(row_typed(ACT_ABORT, DIR_DOWN, mk_word(0, 0, 0, 0, 0, 0)));
      // Two-pixel swipe down at the slowest step, run to completion
      rows.push_back(row_csr(CSR_DISTANCE, 16'hF002));
      rows.push_back(row_csr(CSR_SPEED, 16'h0000));
      rows.push_back(row_typed(ACT_START, DIR_DOWN, mk_word(0, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_TICK, DIR_RIGHT, mk_word(0, -1, 1, 0, 0, 1)));
      repeat (6) rows.push_back(row_item(ACT_TICK, DIR_LEFT));
      // Zero travel: press without a move, abort while released is pending
      rows.push_back(row_csr(CSR_DISTANCE, 16'h0000));
      rows.push_back(row_typed(ACT_START, DIR_RIGHT, mk_word(0, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_TICK, DIR_UP, mk_word(0, 0, 1, 0, 0, 1)));
      rows.push_back(row_item(ACT_TICK, DIR_DOWN));
      rows.push_back(row_typed(ACT_ABORT, DIR_UP, mk_word(0, 0, 0, 1, 0, 0)));
      // Largest distance and speed
      rows.push_back(row_csr(CSR_DISTANCE, 16'h0FFF));
      rows.push_back(row_csr(CSR_SPEED, 16'hFFFF));
      rows.push_back(row_typed(ACT_START, DIR_LEFT, mk_word(0, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_TICK, DIR_DOWN, mk_word(14, 0, 1, 0, 0, 1)));
      rows.push_back(row_typed(ACT_TICK, DIR_RIGHT, mk_word(127, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_START, DIR_DOWN, mk_word(0, 0, 0, 0, 1, 1)));
      rows.push_back(row_typed(ACT_ABORT, DIR_LEFT, mk_word(0, 0, 0, 1, 0, 0)));
      // One-pixel travel goes entirely in the lead move
      rows.push_back(row_csr(CSR_DISTANCE, 16'h0001));
      rows.push_back(row_typed(ACT_START, DIR_UP, mk_word(0, 0, 0, 0, 0, 1)));
      rows.push_back(row_typed(ACT_TICK, DIR_LEFT, mk_word(0, 1, 1, 0, 0, 1)));
      rows.push_back(row_typed(ACT_ABORT, DIR_RIGHT, mk_word(0, 0, 0, 1, 0, 0)));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[k]) begin
         if (rows[k].is_csr) begin
            drain();
            write_reg(rows[k].idx, rows[k].val);
         end else begin
            send_word(rows[k].action, rows[k].dir, rows[k].typed, rows[k].want);
         end
      end

      // Random gestures over several register settings
      set_registers(37, 0);
      hold_asks++;
      run_gestures(ITEMS_PER_SETTING);
      set_registers(4095, 65535);
      run_gestures(ITEMS_PER_SETTING);
      gaps_on = 1'b0;
      set_registers(DISTANCE_RESET, 1000);
      run_gestures(ITEMS_PER_SETTING);
      gaps_on = 1'b1;
      set_registers(3, int'(SPEED_SAT));
      run_gestures(ITEMS_PER_SETTING);
      set_registers($urandom_range(255), $urandom_range(65535));
      hold_asks++;
      run_gestures(ITEMS_PER_SETTING);
      set_registers(2000, int'(SPEED_SAT) - 1);
      run_gestures(ITEMS_PER_SETTING);
      set_registers(150, 46);
      run_gestures(ITEMS_PER_SETTING);

      drain();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
